FILE: rtl/tmsb_pkg.sv
package tmsb_pkg;

    // default sizes of the sample store and the cosine table
    localparam int BUF_DEPTH_DEF   = 262144;
    localparam int COS_ENTRIES_DEF = 1024;

    // fixed field widths
    localparam int IDX_W    = 18;
    localparam int PHASE_W  = 32;
    localparam int SAMPLE_W = 16;
    localparam int AMP_W    = 15;

    // configuration register map
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [AMP_W-1:0] AMP_RESET = 15'd8000;

    // request operation codes
    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } tmsb_op_t;

    // request payload
    typedef struct packed {
        tmsb_op_t            op;
        logic [PHASE_W-1:0]  phase_step;
        logic [IDX_W-1:0]    index;
        logic [IDX_W-1:0]    count;
    } tmsb_in_t;

    // result payload
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       clipped;
    } tmsb_out_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_ADD,
        ST_DRAIN,
        ST_READ,
        ST_DONE
    } tmsb_state_t;

endpackage

FILE: rtl/tmsb_ram.sv
module tmsb_ram
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rd_reg <= mem_reg[raddr];
    end

    assign rdata = rd_reg;

endmodule

FILE: rtl/tone_mix_saturating_buffer.sv
// throughput: one request at a time; an add mixes one sample per cycle through
// the read-modify-write pipeline on the sample memory
// reset: amplitude returns to 8000 and a sweep over max(BUF_DEPTH, COS_ENTRIES) addresses
// zeroes the sample memory and loads the cosine memory before in_ready rises
module tone_mix_saturating_buffer
    import tmsb_pkg::*;
#(
    parameter int BUF_DEPTH   = BUF_DEPTH_DEF,
    parameter int COS_ENTRIES = COS_ENTRIES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tmsb_in_t           in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output tmsb_out_t          out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    localparam int LEN_W     = $clog2(BUF_DEPTH + 1);
    localparam int END_W     = IDX_W + 1;
    localparam int CMP_W     = (LEN_W > END_W) ? LEN_W : END_W;
    localparam int COS_W     = $clog2(COS_ENTRIES);
    localparam int CE_W      = $clog2(COS_ENTRIES + 1);
    localparam int SWEEP_LEN = (BUF_DEPTH > COS_ENTRIES) ? BUF_DEPTH : COS_ENTRIES;
    localparam int SW_W      = $clog2(SWEEP_LEN);

    localparam logic [CMP_W-1:0] BUF_LIM    = CMP_W'(BUF_DEPTH);
    localparam logic [SW_W-1:0]  SWEEP_LAST = SW_W'(SWEEP_LEN - 1);
    localparam logic [SW_W:0]    SMP_END    = (SW_W + 1)'(BUF_DEPTH);
    localparam logic [SW_W:0]    COS_END    = (SW_W + 1)'(COS_ENTRIES);

    // fixed-point constants for building the cosine table
    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
    localparam longint unsigned ONE_Q30    = 64'd1073741824;
    localparam longint unsigned TAYLOR_DIV [7] = '{2, 12, 30, 56, 90, 132, 182};

    // cos(2*pi*k/COS_ENTRIES) in Q1.15, from an eight-term series in Q30
    function automatic logic [COS_ENTRIES-1:0][15:0] cos_rom_build();
        logic [COS_ENTRIES-1:0][15:0] rom;
        longint unsigned a;
        longint unsigned t;
        longint unsigned theta;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          v;
        logic            neg;
        rom = '0;
        for (int k = 0; k < COS_ENTRIES; k++)
        begin
            a = (longint'(k) << 32) / COS_ENTRIES;
            if (a < (64'd1 << 30))
            begin
                t   = a;
                neg = 1'b0;
            end
            else if (a <= (64'd1 << 31))
            begin
                t   = (64'd1 << 31) - a;
                neg = 1'b1;
            end
            else if (a < (64'd3 << 30))
            begin
                t   = a - (64'd1 << 31);
                neg = 1'b1;
            end
            else
            begin
                t   = (64'd1 << 32) - a;
                neg = 1'b0;
            end
            theta = (t * TWO_PI_Q30) >> 32;
            x2    = (theta * theta) >> 30;
            term  = ONE_Q30;
            sum   = longint'(ONE_Q30);
            for (int n = 1; n <= 7; n++)
            begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
                if (n[0])
                begin
                    sum = sum - longint'(term);
                end
                else
                begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0)
            begin
                v = 0;
            end
            else
            begin
                v = (sum * 64'sd32767 + 64'sd536870912) >>> 30;
            end
            if (v > 32767)
            begin
                v = 32767;
            end
            rom[k] = neg ? 16'(-v) : 16'(v);
        end
        return rom;
    endfunction

    localparam logic [COS_ENTRIES-1:0][15:0] COS_ROM = cos_rom_build();

    // control state
    tmsb_state_t       state_reg, state_next;
    logic [SW_W-1:0]   sweep_cnt_reg, sweep_cnt_next;
    logic              sweep_clear_reg, sweep_clear_next;
    logic [LEN_W-1:0]  used_len_reg, used_len_next;
    logic [AMP_W-1:0]  amp_reg, amp_next;
    logic              v1_reg, v1_next;
    logic              v2_reg, v2_next;
    logic              out_valid_reg, out_valid_next;

    // payload state
    logic [CMP_W-1:0]          ptr_reg, ptr_next;
    logic [CMP_W-1:0]          last_reg, last_next;
    logic [PHASE_W-1:0]        phase_reg, phase_next;
    logic [PHASE_W-1:0]        step_reg, step_next;
    logic                      rd_hit_reg, rd_hit_next;
    tmsb_out_t                 res_reg, res_next;
    tmsb_out_t                 out_reg, out_next;
    logic [ADDR_W-1:0]         a1_reg, a1_next;
    logic [ADDR_W-1:0]         a2_reg, a2_next;
    logic signed [31:0]        prod_reg, prod_next;
    logic signed [SAMPLE_W-1:0] samp_reg, samp_next;

    // memory ports
    logic                 smp_we;
    logic [ADDR_W-1:0]    smp_waddr;
    logic [SAMPLE_W-1:0]  smp_wdata;
    logic [ADDR_W-1:0]    smp_raddr;
    logic [SAMPLE_W-1:0]  smp_rdata;
    logic                 cos_we;
    logic [COS_W-1:0]     cos_waddr;
    logic [15:0]          cos_wdata;
    logic [COS_W-1:0]     cos_raddr;
    logic [15:0]          cos_rdata;

    // shared decode
    logic                 req_acc;
    logic                 out_free;
    logic                 cfg_wr;
    logic [CMP_W-1:0]     add_end;
    logic                 add_clip;
    logic [CMP_W-1:0]     add_last;
    logic [CMP_W-1:0]     req_idx;
    logic [CMP_W-1:0]     ptr_inc;
    logic [32+CE_W-1:0]   ph_scaled;
    logic signed [31:0]   amp_s;
    logic signed [31:0]   cos_s;
    logic signed [31:0]   prod_adj;
    logic signed [16:0]   quot;
    logic signed [17:0]   mix_sum;
    logic [SAMPLE_W-1:0]  mix_sat;

    assign req_acc  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign req_idx  = CMP_W'(in_data.index);
    assign add_end  = req_idx + CMP_W'(in_data.count);
    assign add_clip = add_end > BUF_LIM;
    assign add_last = add_clip ? BUF_LIM : add_end;
    assign ptr_inc  = ptr_reg + CMP_W'(1);

    // table index from the phase: (phase * COS_ENTRIES) >> 32
    assign ph_scaled = (32 + CE_W)'(phase_reg) * (32 + CE_W)'(COS_ENTRIES);
    assign cos_raddr = ph_scaled[32 +: COS_W];

    // amplitude times table entry
    assign amp_s = {17'd0, amp_reg};
    assign cos_s = {{16{cos_rdata[15]}}, cos_rdata};

    // divide by 32768 toward zero, add and saturate
    assign prod_adj = prod_reg[31] ? (prod_reg + 32'sd32767) : prod_reg;
    assign quot     = prod_adj[31:15];
    assign mix_sum  = {quot[16], quot} + {{2{samp_reg[15]}}, samp_reg};
    always_comb
    begin
        if (mix_sum[17:15] == 3'b000 || mix_sum[17:15] == 3'b111)
        begin
            mix_sat = mix_sum[15:0];
        end
        else if (mix_sum[17])
        begin
            mix_sat = 16'h8000;
        end
        else
        begin
            mix_sat = 16'h7fff;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_SWEEP:
            begin
                if (sweep_cnt_reg == SWEEP_LAST)
                begin
                    state_next = sweep_clear_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_acc)
                begin
                    unique case (in_data.op)
                        OP_ADD:   state_next = (req_idx < add_last) ? ST_ADD : ST_DONE;
                        OP_READ:  state_next = ST_READ;
                        OP_CLEAR: state_next = ST_SWEEP;
                        OP_NOP:   state_next = ST_DONE;
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_ADD:
            begin
                if (ptr_inc == last_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs: handshake and memory ports
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        smp_raddr = (state_reg == ST_IDLE) ? ADDR_W'(in_data.index) : ADDR_W'(ptr_reg);
        cos_waddr = COS_W'(sweep_cnt_reg);
        cos_wdata = COS_ROM[cos_waddr];
        if (state_reg == ST_SWEEP)
        begin
            smp_we    = ({1'b0, sweep_cnt_reg} < SMP_END);
            smp_waddr = ADDR_W'(sweep_cnt_reg);
            smp_wdata = '0;
            cos_we    = ({1'b0, sweep_cnt_reg} < COS_END);
        end
        else
        begin
            smp_we    = v2_reg;
            smp_waddr = a2_reg;
            smp_wdata = mix_sat;
            cos_we    = 1'b0;
        end
    end

    // datapath next values
    always_comb
    begin
        sweep_cnt_next   = sweep_cnt_reg;
        sweep_clear_next = sweep_clear_reg;
        used_len_next    = used_len_reg;
        amp_next         = amp_reg;
        ptr_next         = ptr_reg;
        last_next        = last_reg;
        phase_next       = phase_reg;
        step_next        = step_reg;
        rd_hit_next      = rd_hit_reg;
        res_next         = res_reg;
        out_next         = out_reg;
        out_valid_next   = out_valid_reg;

        // sweep counter
        if (state_reg == ST_SWEEP)
        begin
            sweep_cnt_next = sweep_cnt_reg + SW_W'(1);
        end

        // request capture
        if (req_acc)
        begin
            res_next.sample  = '0;
            res_next.clipped = 1'b0;
            case (in_data.op)
                OP_ADD:
                begin
                    res_next.clipped = add_clip;
                    ptr_next         = req_idx;
                    last_next        = add_last;
                    phase_next       = '0;
                    step_next        = in_data.phase_step;
                    if (add_last > CMP_W'(used_len_reg))
                    begin
                        used_len_next = LEN_W'(add_last);
                    end
                end
                OP_READ:
                begin
                    rd_hit_next = req_idx < CMP_W'(used_len_reg);
                end
                OP_CLEAR:
                begin
                    used_len_next    = '0;
                    sweep_cnt_next   = '0;
                    sweep_clear_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        // sample walk of an add
        if (state_reg == ST_ADD)
        begin
            ptr_next   = ptr_inc;
            phase_next = phase_reg + step_reg;
        end

        // read data returns
        if (state_reg == ST_READ)
        begin
            res_next.sample = rd_hit_reg ? signed'(smp_rdata) : '0;
        end

        // output register
        if (state_reg == ST_DONE && out_free)
        begin
            out_next       = res_reg;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // configuration write
        if (cfg_wr && !paddr[2])
        begin
            amp_next = pwdata[AMP_W-1:0];
        end
    end

    // mix pipeline next values
    always_comb
    begin
        v1_next   = (state_reg == ST_ADD);
        a1_next   = ADDR_W'(ptr_reg);
        v2_next   = v1_reg;
        a2_next   = a1_reg;
        prod_next = amp_s * cos_s;
        samp_next = signed'(smp_rdata);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_SWEEP;
            sweep_cnt_reg   <= '0;
            sweep_clear_reg <= 1'b0;
            used_len_reg    <= '0;
            amp_reg         <= AMP_RESET;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            sweep_cnt_reg   <= sweep_cnt_next;
            sweep_clear_reg <= sweep_clear_next;
            used_len_reg    <= used_len_next;
            amp_reg         <= amp_next;
            v1_reg          <= v1_next;
            v2_reg          <= v2_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        last_reg   <= last_next;
        phase_reg  <= phase_next;
        step_reg   <= step_next;
        rd_hit_reg <= rd_hit_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
        a1_reg     <= a1_next;
        a2_reg     <= a2_next;
        prod_reg   <= prod_next;
        samp_reg   <= samp_next;
    end

    // sample store
    tmsb_ram
    #(
        .WIDTH (SAMPLE_W),
        .DEPTH (BUF_DEPTH)
    )
    u_smp_ram
    (
        .clk   (clk),
        .we    (smp_we),
        .waddr (smp_waddr),
        .wdata (smp_wdata),
        .raddr (smp_raddr),
        .rdata (smp_rdata)
    );

    // cosine table
    tmsb_ram
    #(
        .WIDTH (16),
        .DEPTH (COS_ENTRIES)
    )
    u_cos_ram
    (
        .clk   (clk),
        .we    (cos_we),
        .waddr (cos_waddr),
        .wdata (cos_wdata),
        .raddr (cos_raddr),
        .rdata (cos_rdata)
    );

    // port outputs
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign pready    = 1'b1;
    assign prdata    = paddr[2] ? '0 : PDATA_W'(amp_reg);

endmodule

FILE: rtl/tmsb_checker.sv
module tmsb_checker
    import tmsb_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input tmsb_out_t out_data
);

    logic [1:0] pend_cnt_reg, pend_cnt_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // requests taken whose result is not yet delivered
    always_comb
    begin
        pend_cnt_next = pend_cnt_reg;
        if (in_acc && !out_acc)
        begin
            pend_cnt_next = pend_cnt_reg + 2'd1;
        end
        else if (!in_acc && out_acc)
        begin
            pend_cnt_next = pend_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_cnt_reg <= '0;
        end
        else
        begin
            pend_cnt_reg <= pend_cnt_next;
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // one request in work at a time
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while another is in work");

    // no result without a request behind it
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_cnt_reg != 2'd0)
        else $error("result with no request outstanding");

    // at most one waiting result plus one request in work
    a_pend_limit: assert property (@(posedge clk) disable iff (!rst_n)
        pend_cnt_reg == 2'd2 |-> !in_ready)
        else $error("ready while two requests outstanding");

endmodule

bind tone_mix_saturating_buffer tmsb_checker u_tmsb_checker (.*);
